// ===== rtl/rbd_pkg.sv =====
// shared types and constants for the ring buffer deque
`default_nettype none

package rbd_pkg;

    localparam int DEPTH      = 16;
    localparam int CELL_COUNT = DEPTH - 1;
    localparam int WORD_W     = 32;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [CELL_COUNT-1:0]    occ_t;

    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // command broadcast to every cell
    typedef struct packed {
        logic go;
        req_t op;
    } cell_ctrl_t;

    // occupancy view of the chain
    typedef struct packed {
        occ_t occ;
        logic full;
        logic empty;
    } chain_stat_t;

endpackage

`default_nettype wire

// ===== rtl/ring_buffer_deque_core.sv =====
// top level of the double-ended queue built from a chain of cells
//
//  channel  dir  handshake           tdata              tuser
//  s_       in   s_tvalid/s_tready   push_value [31:0]  req_type [1:0]
//  m_       out  m_tvalid/m_tready   pop_value  [31:0]  status   [1:0]
//
// one item per cycle while s_tready is high: every cell updates from its neighbors in the same edge
// the result is registered and presented in the cycle after the item is taken
// s_tready is high while the result register is empty or being drained
// reset clears all cell valid bits and the result valid flag; no clearing pass
// the deque holds up to DEPTH-1 words, one cell per word, front at cell 0
`default_nettype none

module ring_buffer_deque_core (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,    // push_value
    input  wire  [1:0]  s_tuser,    // req_type
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,    // pop_value
    output logic [1:0]  m_tuser     // status
);
    import rbd_pkg::*;

    logic        accept;
    req_t        req;
    word_t       push_value;
    word_t       pop_value;
    status_t     status;
    chain_stat_t stat;

    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    word_t       m_tdata_reg;
    status_t     m_tuser_reg;

    // output register frees up in the same cycle it is drained
    assign s_tready   = !m_tvalid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign req        = req_t'(s_tuser);
    assign push_value = word_t'(s_tdata);

    rbd_chain u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .req        (req),
        .push_value (push_value),
        .pop_value  (pop_value),
        .status     (status),
        .stat       (stat)
    );

    // result valid: set on accept, cleared once taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        priority if (accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result payload, loaded only with an accepted item
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= pop_value;
            m_tuser_reg <= status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // occupied cells always form a run starting at the front
    a_occ_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.occ & occ_t'(stat.occ + occ_t'(1))) == '0)
        else $error("deque cells not contiguous from the front");

    // a push that went through leaves the deque non-empty
    a_push_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (req == REQ_PUSH_FRONT || req == REQ_PUSH_BACK) && !stat.full
        |=> !stat.empty)
        else $error("push accepted but deque is empty");

    // a pop that went through leaves room for another word
    a_pop_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (req == REQ_POP_FRONT || req == REQ_POP_BACK) && !stat.empty
        |=> !stat.full)
        else $error("pop accepted but deque is still full");

    // a refused request carries no word
    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser_reg == ST_FULL || m_tuser_reg == ST_EMPTY)
        |-> m_tdata == '0)
        else $error("refused request returned a nonzero word");

endmodule

`default_nettype wire

// ===== rtl/rbd_cell.sv =====
// one storage cell of the deque chain
`default_nettype none

module rbd_cell (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  rbd_pkg::cell_ctrl_t ctrl,
    input  rbd_pkg::word_t      push_value,
    input  wire                 left_valid,
    input  rbd_pkg::word_t      left_data,
    input  wire                 right_valid,
    input  rbd_pkg::word_t      right_data,
    output logic                valid,
    output rbd_pkg::word_t      data,
    output logic                tail
);
    import rbd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    word_t data_reg;
    word_t data_next;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctrl.go) begin
            unique case (ctrl.op)
                REQ_PUSH_FRONT: begin
                    // everything moves one cell toward the back
                    valid_next = left_valid;
                    data_next  = left_data;
                end
                REQ_PUSH_BACK: begin
                    // first free cell takes the word
                    if (!valid_reg && left_valid) begin
                        valid_next = 1'b1;
                        data_next  = push_value;
                    end
                end
                REQ_POP_FRONT: begin
                    valid_next = right_valid;
                    data_next  = right_data;
                end
                REQ_POP_BACK: begin
                    if (valid_reg && !right_valid) begin
                        valid_next = 1'b0;
                    end
                end
                default: begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;
    assign tail  = valid_reg && !right_valid;

endmodule

`default_nettype wire

// ===== rtl/rbd_chain.sv =====
// row of deque cells with request decode and result select
`default_nettype none

module rbd_chain (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   accept,
    input  rbd_pkg::req_t         req,
    input  rbd_pkg::word_t        push_value,
    output rbd_pkg::word_t        pop_value,
    output rbd_pkg::status_t      status,
    output rbd_pkg::chain_stat_t  stat
);
    import rbd_pkg::*;

    occ_t       cell_valid;
    occ_t       cell_tail;
    word_t      cell_data [CELL_COUNT];
    word_t      tail_data;
    cell_ctrl_t ctrl;
    logic       full;
    logic       empty;

    assign full  = cell_valid[CELL_COUNT-1];
    assign empty = !cell_valid[0];

    always_comb begin
        status = ST_DONE;
        unique case (req)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: if (full)  status = ST_FULL;
            REQ_POP_FRONT,  REQ_POP_BACK:  if (empty) status = ST_EMPTY;
            default:                       status = ST_DONE;
        endcase
    end

    assign ctrl.go = accept && (status == ST_DONE);
    assign ctrl.op = req;

    for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
        logic  lv;
        word_t ld;
        logic  rv;
        word_t rd;

        if (i == 0) begin : g_head
            assign lv = 1'b1;
            assign ld = push_value;
        end else begin : g_mid
            assign lv = cell_valid[i-1];
            assign ld = cell_data[i-1];
        end

        if (i == CELL_COUNT - 1) begin : g_end
            assign rv = 1'b0;
            assign rd = '0;
        end else begin : g_inner
            assign rv = cell_valid[i+1];
            assign rd = cell_data[i+1];
        end

        rbd_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .push_value  (push_value),
            .left_valid  (lv),
            .left_data   (ld),
            .right_valid (rv),
            .right_data  (rd),
            .valid       (cell_valid[i]),
            .data        (cell_data[i]),
            .tail        (cell_tail[i])
        );
    end

    // at most one tail flag is set, so an and-or mux picks the back word
    always_comb begin
        tail_data = '0;
        for (int i = 0; i < CELL_COUNT; i++) begin
            tail_data = tail_data | (cell_data[i] & {WORD_W{cell_tail[i]}});
        end
    end

    always_comb begin
        pop_value = '0;
        if (status == ST_DONE) begin
            unique case (req)
                REQ_POP_FRONT:                 pop_value = cell_data[0];
                REQ_POP_BACK:                  pop_value = tail_data;
                REQ_PUSH_FRONT, REQ_PUSH_BACK: pop_value = '0;
                default:                       pop_value = '0;
            endcase
        end
    end

    assign stat.occ   = cell_valid;
    assign stat.full  = full;
    assign stat.empty = empty;

endmodule

`default_nettype wire

// ===== tb/tb_ring_buffer_deque_core.sv =====
// self-checking testbench for the ring buffer deque core
`default_nettype none

module tb_ring_buffer_deque_core;
    import rbd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;  // far above the slowest correct run
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_WAIT  = 20;      // quiet period once every result is in

    // one expected or observed result item
    typedef struct packed {
        word_t   value;
        status_t status;
    } result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // push_value
    logic [1:0]  s_tuser  = '0;   // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // pop_value
    logic [1:0]  m_tuser;         // status

    // predictor state: its own copy of the circular store and both pointers
    word_t   deque_words [DEPTH];
    int      front_ptr = 0;
    int      back_ptr  = 0;
    result_t expected_results [$];

    int error_count    = 0;
    int cycle_count    = 0;
    int stall_left     = 0;
    bit idling_enabled = 1'b1;

    ring_buffer_deque_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #10 aclk = ~aclk;

    // runaway guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // apply one request to the predictor and return the result it causes
    function automatic result_t deque_step(req_t op, word_t val);
        result_t res;
        bit      is_full;
        bit      is_empty;
        res.value  = '0;
        res.status = ST_DONE;
        // one slot stays unused, so full means the slot before front is back
        is_full  = ((front_ptr + DEPTH - 1) % DEPTH) == back_ptr;
        is_empty = front_ptr == back_ptr;
        case (op)
            REQ_PUSH_FRONT: begin
                if (is_full) begin
                    res.status = ST_FULL;
                end else begin
                    front_ptr = (front_ptr + DEPTH - 1) % DEPTH;
                    deque_words[front_ptr] = val;
                end
            end
            REQ_PUSH_BACK: begin
                if (is_full) begin
                    res.status = ST_FULL;
                end else begin
                    deque_words[back_ptr] = val;
                    back_ptr = (back_ptr + 1) % DEPTH;
                end
            end
            REQ_POP_FRONT: begin
                if (is_empty) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.value = deque_words[front_ptr];
                    front_ptr = (front_ptr + 1) % DEPTH;
                end
            end
            default: begin
                if (is_empty) begin
                    res.status = ST_EMPTY;
                end else begin
                    back_ptr  = (back_ptr + DEPTH - 1) % DEPTH;
                    res.value = deque_words[back_ptr];
                end
            end
        endcase
        return res;
    endfunction

    // count a failure; only the first few get printed
    task automatic note_error(string what, result_t want, result_t got, bit has_want);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            if (has_want)
                $display("%0t: %s: expected value %0d status %s, got value %0d status %s",
                         $realtime, what, want.value, want.status.name(),
                         got.value, got.status.name());
            else
                $display("%0t: %s: got value %0d status %s", $realtime, what,
                         got.value, got.status.name());
        end
    endtask

    // result side: random stall bursts on m_tready while idling is on
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idling_enabled && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor: values seen here are the ones present at the edge
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn) begin
            // check first: a result taken at this edge belongs to an older item
            if (m_tvalid && m_tready) begin
                got.value  = m_tdata;
                got.status = status_t'(m_tuser);
                if (expected_results.size() == 0) begin
                    note_error("result with no item pending", got, got, 1'b0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.value !== want.value)
                        note_error("pop_value mismatch", want, got, 1'b1);
                    else if (got.status !== want.status)
                        note_error("status mismatch", want, got, 1'b1);
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(deque_step(req_t'(s_tuser), word_t'(s_tdata)));
        end
    end

    // send one item; returns at the edge where it was taken
    task automatic send_req(req_t op, word_t val);
        if (idling_enabled && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // values lean on the corners of the signed range
    function automatic word_t pick_word();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -1;
            4: return word_t'($signed($urandom_range(0, 200)) - 100);
            default: return word_t'($urandom);
        endcase
    endfunction

    // push with the given percent chance, either end equally likely
    function automatic req_t pick_req(int push_pct);
        bit at_front;
        at_front = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < push_pct)
            return at_front ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
        return at_front ? REQ_POP_FRONT : REQ_POP_BACK;
    endfunction

    // pops on an empty deque right after reset
    task automatic test_empty_pops();
        send_req(REQ_POP_FRONT, 32'sh7fff_ffff);
        send_req(REQ_POP_BACK, -1);
    endtask

    // most negative and most positive words through both ends
    task automatic test_word_extremes();
        send_req(REQ_PUSH_FRONT, 32'sh8000_0000);
        send_req(REQ_PUSH_BACK, 32'sh7fff_ffff);
        send_req(REQ_POP_FRONT, '0);
        send_req(REQ_POP_BACK, '0);
    endtask

    // fill to DEPTH-1 words from both ends, then both pushes are refused
    task automatic test_fill_to_full();
        for (int i = 0; i < DEPTH - 1; i++)
            send_req((i % 2 == 0) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, word_t'($urandom));
        send_req(REQ_PUSH_FRONT, -1);
        send_req(REQ_PUSH_BACK, 32'sh5a5a_a5a5);
    endtask

    // rounds that lean toward filling, draining or neither
    task automatic run_rounds(int n_items, bit allow_idle);
        int sent;
        int round_len;
        int push_pct;
        sent = 0;
        while (sent < n_items) begin
            round_len = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0: push_pct = 85;
                1: push_pct = 15;
                default: push_pct = 50;
            endcase
            // some rounds run with no idling on either side
            idling_enabled = allow_idle && ($urandom_range(0, 3) != 0);
            for (int i = 0; i < round_len && sent < n_items; i++) begin
                send_req(pick_req(push_pct), pick_word());
                sent++;
            end
        end
    endtask

    task automatic test_random_mix();
        run_rounds(1320, 1'b1);
    endtask

    // closing stretch at full rate on both sides
    task automatic test_back_to_back();
        idling_enabled = 1'b0;
        run_rounds(200, 1'b0);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_pops();
        test_word_extremes();
        test_fill_to_full();
        test_random_mix();
        test_back_to_back();

        s_tvalid <= 1'b0;
        // wait out every pending result, then a short quiet period
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/rbd_pkg.sv
rtl/rbd_cell.sv
rtl/rbd_chain.sv
rtl/ring_buffer_deque_core.sv
tb/tb_ring_buffer_deque_core.sv
